[rtl/core/priority_log_slot_replacement_defines.svh]
// ----------------------------------------------------------------------------
// priority_log_slot_replacement_defines
// Assertion macros shared by the log slot table RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LOG_SLOT_REPLACEMENT_DEFINES_SVH
`define PRIORITY_LOG_SLOT_REPLACEMENT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PLSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plsr: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define PLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plsr: next-cycle check failed");

`endif

[rtl/core/plsr_pkg.sv]
// ----------------------------------------------------------------------------
// plsr_pkg
// Sizes, item types and back-end states of the log slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package plsr_pkg;

    // table geometry
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // field widths
    localparam int CAT_W      = 4;
    localparam int STAMP_W    = 64;
    localparam int LINE_W     = 24;
    localparam int REF_W      = 32;
    localparam int PID_W      = 8;
    localparam int SRC_W      = 9;
    localparam int SLOT_OUT_W = 4;
    localparam int FILL_OUT_W = 5;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // source tag for events logged from an interrupt
    localparam logic [SRC_W-1:0]   ISR_TAG   = 9'h100;
    // a zero stamp is stored as this
    localparam logic [STAMP_W-1:0] STAMP_MIN = 64'd1;

    // per-entry data that rides along with the entry
    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [REF_W-1:0]  func;
        logic [REF_W-1:0]  msg;
        logic [SRC_W-1:0]  source;
    } t_entry_data;

    // classified item handed from front to back
    typedef struct packed {
        logic [CAT_W-1:0]   category;
        logic [STAMP_W-1:0] stamp;
        t_entry_data        data;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_WRITE
    } t_back_state;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } t_back_status;

endpackage

`default_nettype wire

[rtl/core/plsr_event_if.sv]
// ----------------------------------------------------------------------------
// plsr_event_if
// Log event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface plsr_event_if import plsr_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CAT_W-1:0]   category;
    logic [STAMP_W-1:0] stamp;
    logic [LINE_W-1:0]  line_number;
    logic [REF_W-1:0]   function_ref;
    logic [REF_W-1:0]   message_ref;
    logic [PID_W-1:0]   process_id;
    logic               from_interrupt;

    modport source (
        output valid, category, stamp, line_number, function_ref, message_ref,
               process_id, from_interrupt,
        input  ready
    );

    modport sink (
        input  valid, category, stamp, line_number, function_ref, message_ref,
               process_id, from_interrupt,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/plsr_result_if.sv]
// ----------------------------------------------------------------------------
// plsr_result_if
// Result channel: valid/ready handshake with slot, fill count and replace flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface plsr_result_if import plsr_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FILL_OUT_W-1:0] fill_count;
    logic                  replaced;

    modport source (
        output valid, slot, fill_count, replaced,
        input  ready
    );

    modport sink (
        input  valid, slot, fill_count, replaced,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/plsr_front.sv]
// ----------------------------------------------------------------------------
// plsr_front
// Accepts log events and turns them into table jobs: zero stamps become one
// and the process id or the interrupt tag becomes the source field.
// ----------------------------------------------------------------------------
`default_nettype none

module plsr_front import plsr_pkg::*; (
    plsr_event_if.sink i_ev,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_job       o_push_job
);

    // handshake passes straight to the queue
    assign o_push_valid = i_ev.valid;
    assign i_ev.ready   = i_push_ready;

    // classify the event
    always_comb begin
        o_push_job.category    = i_ev.category;
        o_push_job.stamp       = (i_ev.stamp == '0) ? STAMP_MIN : i_ev.stamp;
        o_push_job.data.line   = i_ev.line_number;
        o_push_job.data.func   = i_ev.function_ref;
        o_push_job.data.msg    = i_ev.message_ref;
        o_push_job.data.source = i_ev.from_interrupt ? ISR_TAG
                                                     : {1'b0, i_ev.process_id};
    end

endmodule

`default_nettype wire

[rtl/core/plsr_queue.sv]
// ----------------------------------------------------------------------------
// plsr_queue
// Short job queue between the front and the back so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module plsr_queue import plsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    t_job              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_entries[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= QCNT_W'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= QCNT_W'(r_count - 1'b1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entries[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

[rtl/core/plsr_back.sv]
// ----------------------------------------------------------------------------
// plsr_back
// Holds the entry table and the fill count. While filling, a job goes to the
// next free slot; once full, it scans one entry a cycle for the victim, then
// writes the entry and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plsr_back import plsr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  t_job           i_q_job,
    plsr_result_if.source  o_res,
    output t_back_status   o_status
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS);

    // entry table memories
    logic [CAT_W-1:0]   mem_cat   [SLOTS];
    logic [STAMP_W-1:0] mem_stamp [SLOTS];
    t_entry_data        mem_data  [SLOTS];

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [CNT_W-1:0]   r_fill;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_replaced;

    // scan state
    logic               r_issue;
    logic [SLOT_W-1:0]  r_scan_addr;
    logic               r_cmp_valid;
    logic [SLOT_W-1:0]  r_cmp_idx;
    logic [CAT_W-1:0]   r_rd_cat;
    logic [STAMP_W-1:0] r_rd_stamp;
    logic               r_found;
    logic [CAT_W-1:0]   r_best_cat;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [SLOT_W-1:0]  r_victim;

    // result register
    logic                  r_out_valid;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [FILL_OUT_W-1:0] r_out_fill;
    logic                  r_out_replaced;

    logic               w_full;
    logic               w_out_free;
    logic               w_start;
    logic               w_commit;
    logic               w_take;
    logic               w_scan_done;
    logic [CNT_W-1:0]   w_fill_next;

    assign w_full      = (r_fill == FULL_CNT);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_scan_done = r_cmp_valid && (r_cmp_idx == LAST_SLOT);
    assign w_fill_next = w_full ? r_fill : CNT_W'(r_fill + 1'b1);

    // candidate compare: greater category wins, then older stamp, ties keep lower slot
    always_comb begin
        if (r_rd_cat > r_best_cat) begin
            w_take = 1'b1;
        end else if (r_rd_cat == r_best_cat) begin
            w_take = !r_found || (r_rd_stamp < r_best_stamp);
        end else begin
            w_take = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = w_full ? BK_SCAN : BK_WRITE;
                end
            end
            BK_SCAN: begin
                if (w_scan_done) begin
                    n_state = BK_WRITE;
                end
            end
            BK_WRITE: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_ready = 1'b0;
        w_start   = 1'b0;
        w_commit  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_q_ready = 1'b1;
                w_start   = i_q_valid;
            end
            BK_WRITE: begin
                w_commit = w_out_free;
            end
            default: begin
                o_q_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_fill      <= '0;
            r_issue     <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_fill <= w_fill_next;
            end
            if (w_start) begin
                r_issue     <= w_full;
                r_cmp_valid <= 1'b0;
            end else if (r_state == BK_SCAN) begin
                r_issue     <= r_issue && (r_scan_addr != LAST_SLOT);
                r_cmp_valid <= r_issue;
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job, scan and result datapath
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_job        <= i_q_job;
            r_slot       <= r_fill[SLOT_W-1:0];
            r_replaced   <= w_full;
            r_scan_addr  <= '0;
            r_found      <= 1'b0;
            r_best_cat   <= i_q_job.category;
            r_best_stamp <= '1;
            r_victim     <= LAST_SLOT;
        end else if (r_state == BK_SCAN) begin
            if (r_issue && (r_scan_addr != LAST_SLOT)) begin
                r_scan_addr <= SLOT_W'(r_scan_addr + 1'b1);
            end
            r_cmp_idx <= r_scan_addr;
            if (r_cmp_valid && w_take) begin
                r_found      <= 1'b1;
                r_best_cat   <= r_rd_cat;
                r_best_stamp <= r_rd_stamp;
                r_victim     <= r_cmp_idx;
            end
            if (w_scan_done) begin
                r_slot <= w_take ? r_cmp_idx : r_victim;
            end
        end
        if (w_commit) begin
            r_out_slot     <= SLOT_OUT_W'(r_slot);
            r_out_fill     <= FILL_OUT_W'(w_fill_next);
            r_out_replaced <= r_replaced;
        end
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            mem_cat[r_slot]   <= r_job.category;
            mem_stamp[r_slot] <= r_job.stamp;
            mem_data[r_slot]  <= r_job.data;
        end
        r_rd_cat   <= mem_cat[r_scan_addr];
        r_rd_stamp <= mem_stamp[r_scan_addr];
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.slot       = r_out_slot;
    assign o_res.fill_count = r_out_fill;
    assign o_res.replaced   = r_out_replaced;

    assign o_status.busy = (r_state != BK_IDLE);
    assign o_status.fill = r_fill;

endmodule

`default_nettype wire

[rtl/core/priority_log_slot_replacement.sv]
// ----------------------------------------------------------------------------
// priority_log_slot_replacement
// Log slot table with category-based victim selection once the table is full.
// ----------------------------------------------------------------------------
// Each accepted log event yields one result item. While the table is filling,
// the back end pops an item and then writes it. Once the table is full, the
// victim scan between pop and write reads one entry per cycle through the
// single registered read port of the table memory.
// A two-entry queue lets the event side keep accepting while the back end
// scans, and the result register holds a finished item until it is taken.
// The table needs no clearing pass after reset; entries are only scanned once
// every slot has been written.
`default_nettype none
`include "priority_log_slot_replacement_defines.svh"

module priority_log_slot_replacement import plsr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plsr_event_if.sink     i_ev,
    plsr_result_if.source  o_res
);

    logic         w_q_push_valid;
    logic         w_q_push_ready;
    t_job         w_q_push_job;
    logic         w_q_pop_valid;
    logic         w_q_pop_ready;
    t_job         w_q_pop_job;
    t_back_status w_back_status;

    // event classification
    plsr_front u_front (
        .i_ev         (i_ev),
        .o_push_valid (w_q_push_valid),
        .i_push_ready (w_q_push_ready),
        .o_push_job   (w_q_push_job)
    );

    // decoupling queue
    plsr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_q_push_valid),
        .o_push_ready (w_q_push_ready),
        .i_push_job   (w_q_push_job),
        .o_pop_valid  (w_q_pop_valid),
        .i_pop_ready  (w_q_pop_ready),
        .o_pop_job    (w_q_pop_job)
    );

    // table update and victim scan
    plsr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_pop_valid),
        .o_q_ready (w_q_pop_ready),
        .i_q_job   (w_q_pop_job),
        .o_res     (o_res),
        .o_status  (w_back_status)
    );

    // an accepted item is waiting in the queue on the next cycle
    `PLSR_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_ev.valid && i_ev.ready, w_q_pop_valid)

    // an idle back end picks up a waiting item at once
    `PLSR_ASSERT_NEXT(a_back_picks, i_clk, i_rst_n, w_q_pop_valid && !w_back_status.busy, w_back_status.busy)

    // a replacement only happens with a full table
    `PLSR_ASSERT_SAME(a_replace_full, i_clk, i_rst_n, o_res.valid && o_res.replaced, o_res.fill_count == FILL_OUT_W'(SLOTS))

    // fill count saturates at the table size
    `PLSR_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, w_back_status.fill <= CNT_W'(SLOTS))

endmodule

`default_nettype wire
